FILE: hdl/stl_pkg.sv
package stl_pkg;

  localparam int unsigned NumKeywords = 6;
  localparam int unsigned MaxResults  = 3;

  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_STRING  = 3'd3,
    KIND_OPER    = 3'd4,
    KIND_END     = 3'd5
  } kind_e;

  localparam logic [7:0] CHAR_EQ     = 8'h3d;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_UNDER  = 8'h5f;

  // keyword text, padded with zeros to eight positions
  localparam logic [7:0] KW_TEXT [NumKeywords][8] = '{
    '{8'h53, 8'h45, 8'h4c, 8'h45, 8'h43, 8'h54, 8'h00, 8'h00},
    '{8'h57, 8'h48, 8'h45, 8'h52, 8'h45, 8'h00, 8'h00, 8'h00},
    '{8'h49, 8'h4e, 8'h53, 8'h45, 8'h52, 8'h54, 8'h00, 8'h00},
    '{8'h44, 8'h45, 8'h4c, 8'h45, 8'h54, 8'h45, 8'h00, 8'h00},
    '{8'h55, 8'h50, 8'h44, 8'h41, 8'h54, 8'h45, 8'h00, 8'h00},
    '{8'h41, 8'h4c, 8'h4c, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] KW_LEN [NumKeywords] = '{
    3'd6, 3'd5, 3'd6, 3'd6, 3'd6, 3'd3
  };

  typedef struct packed {
    logic       is_close;
    logic [7:0] char_out;
    logic [2:0] token_kind;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]                 cnt;
    res_t [MaxResults-1:0]      res;
  } burst_t;

endpackage

FILE: hdl/stl_if.sv
interface stl_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] byte_in;

  modport source (output valid, output operation, output byte_in, input ready);
  modport sink (input valid, input operation, input byte_in, output ready);
endinterface

interface stl_out_if;
  logic       valid;
  logic       ready;
  logic       is_close;
  logic [7:0] char_out;
  logic [2:0] token_kind;
  logic       last;

  modport source (output valid, output is_close, output char_out, output token_kind,
                  output last, input ready);
  modport sink (input valid, input is_close, input char_out, input token_kind,
                input last, output ready);
endinterface

FILE: hdl/stl_front.sv
module stl_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  stl_in_if.sink           in_i,
  input  logic             full_i,
  output logic             push_o,
  output stl_pkg::burst_t  burst_o
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_STR  = 2'd3
  } mode_e;

  mode_e      mode_q, mode_d;
  logic       quote_q, quote_d;
  logic [5:0] mask_q, mask_d;
  logic [2:0] len_q, len_d;

  logic       accept;
  logic [7:0] c;
  logic [7:0] upper;
  logic       is_alpha;
  logic       is_digit;
  logic       is_quote;
  logic [7:0] cur_quote;
  logic       kw_hit;
  logic [5:0] mask_cont;
  logic [5:0] mask_start;

  stl_pkg::res_t [stl_pkg::MaxResults-1:0] res;
  logic [1:0] n;
  logic       do_wchar, do_char, do_close, do_idle, do_end;
  stl_pkg::kind_e close_kind;

  function automatic logic [5:0] kw_mask_next(logic [5:0] mask, logic [2:0] pos,
                                              logic [7:0] u);
    logic [5:0] m;
    m = mask;
    for (int k = 0; k < stl_pkg::NumKeywords; k++) begin
      if (pos >= stl_pkg::KW_LEN[k] || stl_pkg::KW_TEXT[k][pos] != u) begin
        m[k] = 1'b0;
      end
    end
    return m;
  endfunction

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = !full_i;
  assign c         = in_i.byte_in;
  assign is_alpha  = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  assign is_digit  = (c >= 8'h30 && c <= 8'h39);
  assign is_quote  = (c == stl_pkg::CHAR_DQUOTE) || (c == stl_pkg::CHAR_SQUOTE);
  assign upper     = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
  assign cur_quote = quote_q ? stl_pkg::CHAR_DQUOTE : stl_pkg::CHAR_SQUOTE;
  assign mask_cont  = kw_mask_next(mask_q, len_q, upper);
  assign mask_start = kw_mask_next(6'h3f, 3'd0, upper);

  always_comb begin
    kw_hit = 1'b0;
    for (int k = 0; k < stl_pkg::NumKeywords; k++) begin
      if (mask_q[k] && len_q == stl_pkg::KW_LEN[k]) begin
        kw_hit = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (mode_q)
      MODE_WORD: close_kind = kw_hit ? stl_pkg::KIND_KEYWORD : stl_pkg::KIND_IDENT;
      MODE_NUM:  close_kind = stl_pkg::KIND_NUMBER;
      default:   close_kind = stl_pkg::KIND_STRING;
    endcase
  end

  always_comb begin
    do_wchar = 1'b0;
    do_char  = 1'b0;
    do_close = 1'b0;
    do_idle  = 1'b0;
    do_end   = 1'b0;
    if (in_i.operation) begin
      do_close = (mode_q != MODE_IDLE);
      do_end   = 1'b1;
    end else begin
      unique case (mode_q)
        MODE_WORD: begin
          if (is_alpha || is_digit || c == stl_pkg::CHAR_UNDER) begin
            do_wchar = 1'b1;
          end else begin
            do_close = 1'b1;
            do_idle  = 1'b1;
          end
        end
        MODE_NUM: begin
          if (is_digit) begin
            do_char = 1'b1;
          end else begin
            do_close = 1'b1;
            do_idle  = 1'b1;
          end
        end
        MODE_STR: begin
          if (c == cur_quote) begin
            do_close = 1'b1;
          end else begin
            do_char = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase
    end
  end

  always_comb begin
    res     = '0;
    n       = 2'd0;
    mode_d  = mode_q;
    quote_d = quote_q;
    mask_d  = mask_q;
    len_d   = len_q;

    if (do_wchar) begin
      res[n] = '{is_close: 1'b0, char_out: upper, token_kind: 3'(stl_pkg::KIND_KEYWORD),
                 last: 1'b0};
      n      = n + 2'd1;
      mask_d = mask_cont;
      len_d  = (len_q == 3'd7) ? len_q : len_q + 3'd1;
    end
    if (do_char) begin
      res[n] = '{is_close: 1'b0, char_out: c, token_kind: 3'(stl_pkg::KIND_KEYWORD),
                 last: 1'b0};
      n      = n + 2'd1;
    end
    if (do_close) begin
      res[n] = '{is_close: 1'b1, char_out: 8'h00, token_kind: 3'(close_kind), last: 1'b0};
      n      = n + 2'd1;
      mode_d = MODE_IDLE;
      mask_d = 6'h3f;
      len_d  = 3'd0;
    end
    if (do_idle) begin
      priority if (is_alpha) begin
        mode_d = MODE_WORD;
        mask_d = mask_start;
        len_d  = 3'd1;
        res[n] = '{is_close: 1'b0, char_out: upper, token_kind: 3'(stl_pkg::KIND_KEYWORD),
                   last: 1'b0};
        n      = n + 2'd1;
      end else if (is_digit) begin
        mode_d = MODE_NUM;
        res[n] = '{is_close: 1'b0, char_out: c, token_kind: 3'(stl_pkg::KIND_KEYWORD),
                   last: 1'b0};
        n      = n + 2'd1;
      end else if (is_quote) begin
        mode_d  = MODE_STR;
        quote_d = (c == stl_pkg::CHAR_DQUOTE);
      end else if (c == stl_pkg::CHAR_EQ) begin
        res[n] = '{is_close: 1'b0, char_out: stl_pkg::CHAR_EQ,
                   token_kind: 3'(stl_pkg::KIND_KEYWORD), last: 1'b0};
        n      = n + 2'd1;
        res[n] = '{is_close: 1'b1, char_out: 8'h00, token_kind: 3'(stl_pkg::KIND_OPER),
                   last: 1'b0};
        n      = n + 2'd1;
      end else begin
      end
    end
    if (do_end) begin
      res[n] = '{is_close: 1'b1, char_out: 8'h00, token_kind: 3'(stl_pkg::KIND_END),
                 last: 1'b0};
      n       = n + 2'd1;
      mode_d  = MODE_IDLE;
      quote_d = 1'b0;
      mask_d  = 6'h3f;
      len_d   = 3'd0;
    end
    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end
  end

  assign push_o      = accept && (n != 2'd0);
  assign burst_o.cnt = n;
  assign burst_o.res = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      quote_q <= 1'b0;
      mask_q  <= 6'h3f;
      len_q   <= 3'd0;
    end else if (accept) begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
      mask_q  <= mask_d;
      len_q   <= len_d;
    end
  end

endmodule

FILE: hdl/stl_fifo.sv
module stl_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  stl_pkg::burst_t data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output stl_pkg::burst_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  stl_pkg::burst_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/stl_back.sv
module stl_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  stl_pkg::burst_t head_i,
  output logic            pop_o,
  stl_out_if.source       out_o
);

  logic [1:0]    idx_q;
  logic          fire;
  logic          at_end;
  stl_pkg::res_t cur;

  assign cur    = head_i.res[idx_q];
  assign fire   = out_o.valid && out_o.ready;
  assign at_end = (idx_q == head_i.cnt - 2'd1);
  assign pop_o  = fire && at_end;

  assign out_o.valid      = !empty_i;
  assign out_o.is_close   = cur.is_close;
  assign out_o.char_out   = cur.char_out;
  assign out_o.token_kind = cur.token_kind;
  assign out_o.last       = cur.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (fire) begin
      idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

FILE: hdl/sql_token_lexer_core.sv
// channel  | dir | handshake    | payload
// in_i     | in  | valid/ready  | operation, byte_in
// out_o    | out | valid/ready  | is_close, char_out, token_kind, last
//
// one byte or end mark accepted per cycle while the burst queue has room
// each request yields zero to three results, drained one per cycle from the queue while out_o is ready
// sustained rate: one request per cycle when requests give at most one result,
// otherwise set by the output port at one result per cycle
// reset sets lexer mode to idle and keyword mask to all ones, clears length and queue pointers
// output stalls back up only through the queue filling
module sql_token_lexer_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  stl_in_if.sink     in_i,
  stl_out_if.source  out_o
);

  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  stl_pkg::burst_t burst_in;
  stl_pkg::burst_t burst_head;

  stl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .burst_o (burst_in)
  );

  stl_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (burst_in),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .data_o  (burst_head)
  );

  stl_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (burst_head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

FILE: dv/sql_token_lexer_core_tb.sv
`timescale 1ns / 1ps

module sql_token_lexer_core_tb;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned DrainCycles = 20;
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END = 1'b1;

  typedef enum logic [1:0] {
    LX_IDLE,
    LX_WORD,
    LX_NUM,
    LX_STR
  } lex_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  stl_in_if in_if ();
  stl_out_if out_if ();

  sql_token_lexer_core uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // lexer shadow state
  lex_mode_e       lx_mode = LX_IDLE;
  logic            lx_dquote = 1'b0;
  logic [5:0]      kw_hits = '1;
  logic [2:0]      word_len = '0;
  stl_pkg::res_t   step_res[$];
  stl_pkg::res_t   token_exp[$];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned sent_reqs;
  int unsigned errs;
  int unsigned cycles;

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void add_res(logic cl, logic [7:0] ch, stl_pkg::kind_e kind);
    stl_pkg::res_t r;
    r.is_close = cl;
    r.char_out = ch;
    r.token_kind = kind;
    r.last = 1'b0;
    step_res = {step_res, r};
  endfunction

  function automatic void word_char(logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    for (int k = 0; k < stl_pkg::NumKeywords; k++) begin
      if (word_len >= stl_pkg::KW_LEN[k] || stl_pkg::KW_TEXT[k][word_len] != u) begin
        kw_hits[k] = 1'b0;
      end
    end
    if (word_len != 3'd7) word_len = word_len + 3'd1;
    add_res(1'b0, u, stl_pkg::KIND_KEYWORD);
  endfunction

  function automatic void close_token();
    stl_pkg::kind_e kind;
    case (lx_mode)
      LX_WORD: begin
        kind = stl_pkg::KIND_IDENT;
        for (int k = 0; k < stl_pkg::NumKeywords; k++) begin
          if (kw_hits[k] && stl_pkg::KW_LEN[k] == word_len) kind = stl_pkg::KIND_KEYWORD;
        end
        add_res(1'b1, 8'h00, kind);
      end
      LX_NUM: add_res(1'b1, 8'h00, stl_pkg::KIND_NUMBER);
      LX_STR: add_res(1'b1, 8'h00, stl_pkg::KIND_STRING);
      default: ;
    endcase
    lx_mode = LX_IDLE;
    kw_hits = '1;
    word_len = '0;
  endfunction

  function automatic void idle_char(logic [7:0] c);
    if (is_letter(c)) begin
      lx_mode = LX_WORD;
      kw_hits = '1;
      word_len = '0;
      word_char(c);
    end else if (is_digit(c)) begin
      lx_mode = LX_NUM;
      add_res(1'b0, c, stl_pkg::KIND_KEYWORD);
    end else if (c == stl_pkg::CHAR_DQUOTE || c == stl_pkg::CHAR_SQUOTE) begin
      lx_mode = LX_STR;
      lx_dquote = (c == stl_pkg::CHAR_DQUOTE);
    end else if (c == stl_pkg::CHAR_EQ) begin
      add_res(1'b0, stl_pkg::CHAR_EQ, stl_pkg::KIND_KEYWORD);
      add_res(1'b1, 8'h00, stl_pkg::KIND_OPER);
    end
  endfunction

  function automatic void lex_step(logic op, logic [7:0] c);
    step_res.delete();
    if (op == OP_END) begin
      close_token();
      add_res(1'b1, 8'h00, stl_pkg::KIND_END);
      lx_dquote = 1'b0;
    end else begin
      case (lx_mode)
        LX_WORD: begin
          if (is_letter(c) || is_digit(c) || c == stl_pkg::CHAR_UNDER) begin
            word_char(c);
          end else begin
            close_token();
            idle_char(c);
          end
        end
        LX_NUM: begin
          if (is_digit(c)) begin
            add_res(1'b0, c, stl_pkg::KIND_KEYWORD);
          end else begin
            close_token();
            idle_char(c);
          end
        end
        LX_STR: begin
          if (c == (lx_dquote ? stl_pkg::CHAR_DQUOTE : stl_pkg::CHAR_SQUOTE)) close_token();
          else add_res(1'b0, c, stl_pkg::KIND_KEYWORD);
        end
        default: idle_char(c);
      endcase
    end
    if (step_res.size() != 0) step_res[step_res.size()-1].last = 1'b1;
    token_exp = {token_exp, step_res};
  endfunction

  // prediction on accepted requests, then comparison of accepted results
  always @(posedge clk_i) begin
    stl_pkg::res_t got;
    stl_pkg::res_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) lex_step(in_if.operation, in_if.byte_in);
      if (out_if.valid && out_if.ready) begin
        got.is_close = out_if.is_close;
        got.char_out = out_if.char_out;
        got.token_kind = out_if.token_kind;
        got.last = out_if.last;
        if (token_exp.size() == 0) begin
          $display("%0t: unexpected result close=%0d char=%02h kind=%0d last=%0d", $time,
                   got.is_close, got.char_out, got.token_kind, got.last);
          errs++;
        end else begin
          want = token_exp.pop_front();
          if (got.is_close !== want.is_close || got.char_out !== want.char_out ||
              got.token_kind !== want.token_kind || got.last !== want.last) begin
            $display("%0t: mismatch exp close=%0d char=%02h kind=%0d last=%0d", $time,
                     want.is_close, want.char_out, want.token_kind, want.last);
            $display("%0t:          got close=%0d char=%02h kind=%0d last=%0d", $time,
                     got.is_close, got.char_out, got.token_kind, got.last);
            errs++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_req(input logic op, input logic [7:0] b, input bit tally);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.byte_in <= b;
    do @(posedge clk_i); while (!in_if.ready);
    if (tally) sent_reqs++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_req(OP_DATA, s[i], 1'b1);
  endtask

  task automatic test_directed();
    send_req(OP_END, 8'h00, 1'b1);
    // word closed by operator gives three results
    send_text("all=");
    send_text("12");
    send_req(OP_DATA, 8'h80, 1'b1);
    send_text(" ''");
    // unterminated string holding the other quote and extreme bytes
    send_text("\"x'");
    send_req(OP_DATA, 8'hff, 1'b1);
    send_req(OP_DATA, 8'h00, 1'b1);
    send_req(OP_END, 8'hff, 1'b1);
    // long word that starts like a keyword
    send_text("selectxy");
    send_req(OP_END, 8'h5a, 1'b1);
  endtask

  task automatic send_separator();
    logic [7:0] b;
    case ($urandom_range(5))
      0: b = " ";
      1: b = 8'h09;
      2: b = ",";
      3: b = "(";
      4: b = 8'h0a;
      default: b = 8'h80 | 8'($urandom_range(127));
    endcase
    send_req(OP_DATA, b, 1'b1);
  endtask

  task automatic send_token();
    int unsigned k;
    int unsigned n;
    int unsigned r;
    logic [7:0] c;
    logic [7:0] q;
    case ($urandom_range(9))
      0, 1: begin
        k = $urandom_range(stl_pkg::NumKeywords - 1);
        n = stl_pkg::KW_LEN[k];
        if ($urandom_range(5) == 0) n = n - 1;
        for (int i = 0; i < n; i++) begin
          c = stl_pkg::KW_TEXT[k][i];
          if ($urandom_range(1)) c = c | 8'h20;
          send_req(OP_DATA, c, 1'b1);
        end
      end
      2, 3: begin
        n = ($urandom_range(7) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          r = (i == 0) ? $urandom_range(51) : $urandom_range(62);
          if (r < 26) c = 8'("A" + r);
          else if (r < 52) c = 8'("a" + r - 26);
          else if (r < 62) c = 8'("0" + r - 52);
          else c = stl_pkg::CHAR_UNDER;
          send_req(OP_DATA, c, 1'b1);
        end
      end
      4: begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) send_req(OP_DATA, 8'("0" + $urandom_range(9)), 1'b1);
      end
      5, 6: begin
        q = $urandom_range(1) ? stl_pkg::CHAR_DQUOTE : stl_pkg::CHAR_SQUOTE;
        send_req(OP_DATA, q, 1'b1);
        n = $urandom_range(6);
        for (int i = 0; i < n; i++) begin
          do c = 8'($urandom_range(255)); while (c == q);
          send_req(OP_DATA, c, 1'b1);
        end
        if ($urandom_range(7) != 0) send_req(OP_DATA, q, 1'b1);
      end
      7: send_req(OP_DATA, stl_pkg::CHAR_EQ, 1'b1);
      8: send_req(OP_DATA, 8'($urandom_range(255)), 1'b1);
      default: send_req(OP_END, 8'($urandom_range(255)), 1'b1);
    endcase
    if ($urandom_range(9) < 6) send_separator();
  endtask

  task automatic test_random_stream(input int unsigned count);
    int unsigned goal;
    goal = sent_reqs + count;
    while (sent_reqs < goal) send_token();
    send_req(OP_END, 8'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.operation = OP_DATA;
    in_if.byte_in = 8'h00;
    sent_reqs = 0;
    src_idle_pct = 19;
    snk_idle_pct = 61;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_stream(130);
    src_idle_pct = 61;
    snk_idle_pct = 19;
    test_random_stream(130);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_stream(130);

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (token_exp.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errs == 0 && token_exp.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/stl_pkg.sv
hdl/stl_if.sv
hdl/stl_front.sv
hdl/stl_fifo.sv
hdl/stl_back.sv
hdl/sql_token_lexer_core.sv
dv/sql_token_lexer_core_tb.sv
